[rtl/led_frame_serial_receiver_assert.svh]
// ----------------------------------------------------------------------------
// LED frame receiver assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LED_FRAME_SERIAL_RECEIVER_ASSERT_SVH
`define LED_FRAME_SERIAL_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LFRX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfrx assertion failed");
`define LFRX_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lfrx forbidden condition seen");
`else
`define LFRX_ASSERT(label, clk, rst_n, prop)
`define LFRX_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/lfrx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame receiver package
// Shared constants, command and write-port types, and state encodings.
// ----------------------------------------------------------------------------
package lfrx_pkg;

    localparam int LED_COUNT = 60;
    localparam int PIX_W     = 6;

    localparam logic [7:0]  HDR_BYTE         = 8'hAA;
    localparam logic [7:0]  STATUS_REQ       = 8'h42;
    localparam logic [7:0]  ACK_OK           = 8'h01;
    localparam logic [7:0]  ACK_ERR          = 8'hFF;
    localparam logic [7:0]  FIFO_FULL_LEVEL  = 8'd128;
    localparam logic [7:0]  MIN_INTERVAL_RST = 8'd33;
    localparam logic [15:0] TIMEOUT_RST      = 16'd1000;
    localparam logic [16:0] SILENCE_MAX      = 17'h1FFFF;

    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_TIMEOUT      = 1'b1;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_PIX  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COUNT,
        PH_DATA,
        PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SHOW,
        B_ACK
    } t_bstate;

    typedef struct packed {
        logic             is_frame;
        logic [7:0]       tx_byte;
        logic [PIX_W-1:0] leds;
    } t_cmd;

    typedef struct packed {
        logic             we;
        logic [1:0]       lane;
        logic [PIX_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

endpackage

[rtl/lfrx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame receiver command queue
// Two-entry queue carrying commands from the front end to the back end.
// ----------------------------------------------------------------------------
module lfrx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfrx_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output lfrx_pkg::t_cmd o_cmd
);
    import lfrx_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       n_wr_ptr;
    logic       r_rd_ptr;
    logic       n_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/lfrx_front.sv]
`timescale 1ns / 1ps
`include "led_frame_serial_receiver_assert.svh"
// ----------------------------------------------------------------------------
// LED frame receiver front end
// Accepts beats, tracks framing and time, stores colour bytes and queues
// acknowledge, status and frame commands.
// ----------------------------------------------------------------------------
module lfrx_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_mode,
    input  logic [7:0]     i_rx_byte,
    input  logic [7:0]     i_fifo_level,
    input  logic [7:0]     i_min_interval,
    input  logic [15:0]    i_timeout,
    input  logic           i_q_full,
    input  logic           i_frame_done,
    output logic           o_push,
    output lfrx_pkg::t_cmd o_cmd,
    output lfrx_pkg::t_wr  o_wr
);
    import lfrx_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [31:0]      r_now;
    logic [31:0]      n_now;
    logic [31:0]      r_last_frame;
    logic [31:0]      n_last_frame;
    logic [PIX_W-1:0] r_frame_leds;
    logic [PIX_W-1:0] n_frame_leds;
    logic [9:0]       r_byte_count;
    logic [9:0]       n_byte_count;
    logic [16:0]      r_silence;
    logic [16:0]      n_silence;
    logic [1:0]       r_lane;
    logic [1:0]       n_lane;
    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] n_pix;
    logic             r_frame_busy;
    logic             n_frame_busy;

    logic             accept;
    logic             is_byte;
    logic             too_soon;
    logic             bad_count;
    logic [16:0]      silence_inc;
    logic             timeout_hit;
    logic             frame_end;
    logic [7:0]       level_sat;
    logic [15:0]      level_prod;

    assign o_ready     = !i_q_full && !((r_phase == PH_DATA) && r_frame_busy);
    assign accept      = i_valid && o_ready;
    assign is_byte     = (i_mode == MODE_BYTE);
    assign too_soon    = (r_now - r_last_frame) < {24'd0, i_min_interval};
    assign bad_count   = (i_rx_byte == 8'd0) || (i_rx_byte > 8'(LED_COUNT));
    assign silence_inc = (r_silence == SILENCE_MAX) ? r_silence : r_silence + 17'd1;
    assign timeout_hit = silence_inc > {1'b0, i_timeout};
    assign frame_end   = (r_lane == LANE_BLUE) && (r_pix == r_frame_leds - 6'd1);
    assign level_sat   = (i_fifo_level > FIFO_FULL_LEVEL) ? FIFO_FULL_LEVEL : i_fifo_level;
    assign level_prod  = {level_sat, 8'd0} - {8'd0, level_sat};

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (is_byte && (i_rx_byte == HDR_BYTE)) begin
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (is_byte) begin
                        if (too_soon) begin
                            n_phase = (i_rx_byte == 8'd0) ? PH_IDLE : PH_DISCARD;
                        end else if (bad_count) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DISCARD: begin
                    if (is_byte && (r_byte_count <= 10'd1)) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    if (is_byte ? frame_end : timeout_hit) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        n_now        = r_now;
        n_last_frame = r_last_frame;
        n_frame_leds = r_frame_leds;
        n_byte_count = r_byte_count;
        n_silence    = r_silence;
        n_lane       = r_lane;
        n_pix        = r_pix;
        n_frame_busy = r_frame_busy;
        o_push       = 1'b0;
        o_cmd        = '{is_frame: 1'b0, tx_byte: ACK_ERR, leds: r_frame_leds};
        o_wr         = '{we: 1'b0, lane: r_lane, addr: r_pix, data: i_rx_byte};
        if (i_frame_done) begin
            n_frame_busy = 1'b0;
        end
        if (accept) begin
            if (!is_byte) begin
                n_now = r_now + 32'd1;
                if (r_phase == PH_DATA) begin
                    n_silence = silence_inc;
                    if (timeout_hit) begin
                        o_push = 1'b1;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_rx_byte == STATUS_REQ) begin
                            o_push        = 1'b1;
                            o_cmd.tx_byte = level_prod[14:7];
                        end
                    end
                    PH_COUNT: begin
                        if (too_soon) begin
                            n_byte_count = {2'd0, i_rx_byte} + {1'b0, i_rx_byte, 1'b0};
                        end else begin
                            n_last_frame = r_now;
                            if (bad_count) begin
                                o_push = 1'b1;
                            end else begin
                                n_frame_leds = i_rx_byte[PIX_W-1:0];
                                n_silence    = 17'd0;
                                n_lane       = LANE_RED;
                                n_pix        = '0;
                            end
                        end
                    end
                    PH_DISCARD: begin
                        if (r_byte_count != 10'd0) begin
                            n_byte_count = r_byte_count - 10'd1;
                        end
                    end
                    PH_DATA: begin
                        n_silence = 17'd0;
                        o_wr.we   = 1'b1;
                        if (frame_end) begin
                            o_push         = 1'b1;
                            o_cmd.is_frame = 1'b1;
                            o_cmd.tx_byte  = ACK_OK;
                            n_frame_busy   = 1'b1;
                        end else if (r_lane == LANE_BLUE) begin
                            n_lane = LANE_RED;
                            n_pix  = r_pix + 6'd1;
                        end else begin
                            n_lane = r_lane + 2'd1;
                        end
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_now        <= 32'd0;
            r_last_frame <= 32'd0;
            r_frame_leds <= '0;
            r_byte_count <= 10'd0;
            r_silence    <= 17'd0;
            r_lane       <= LANE_RED;
            r_pix        <= '0;
            r_frame_busy <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_now        <= n_now;
            r_last_frame <= n_last_frame;
            r_frame_leds <= n_frame_leds;
            r_byte_count <= n_byte_count;
            r_silence    <= n_silence;
            r_lane       <= n_lane;
            r_pix        <= n_pix;
            r_frame_busy <= n_frame_busy;
        end
    end

    `LFRX_NEVER(a_no_write_while_busy, i_clk, i_rst_n, o_wr.we && r_frame_busy)
    `LFRX_ASSERT(a_frame_from_data, i_clk, i_rst_n,
        (o_push && o_cmd.is_frame) |-> (r_phase == PH_DATA && r_frame_leds != '0))
    `LFRX_ASSERT(a_busy_set_by_frame, i_clk, i_rst_n,
        $rose(r_frame_busy) |-> $past(o_push && o_cmd.is_frame))

endmodule

[rtl/lfrx_back.sv]
`timescale 1ns / 1ps
`include "led_frame_serial_receiver_assert.svh"
// ----------------------------------------------------------------------------
// LED frame receiver back end
// Holds the frame store, executes queued commands and drives the result
// output register.
// ----------------------------------------------------------------------------
module lfrx_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  lfrx_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_frame_done,
    input  lfrx_pkg::t_wr              i_wr,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [7:0]                 o_tx_byte,
    output logic [lfrx_pkg::PIX_W-1:0] o_pixel_index,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic                       o_last
);
    import lfrx_pkg::*;

    logic [7:0] r_mem_red   [LED_COUNT];
    logic [7:0] r_mem_green [LED_COUNT];
    logic [7:0] r_mem_blue  [LED_COUNT];
    logic [7:0] r_rd_red;
    logic [7:0] r_rd_green;
    logic [7:0] r_rd_blue;

    t_bstate          r_state;
    t_bstate          n_state;
    logic [PIX_W-1:0] r_idx;
    logic [PIX_W-1:0] n_idx;
    logic [PIX_W-1:0] r_leds;
    logic [PIX_W-1:0] n_leds;

    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_kind;
    logic             n_kind;
    logic [7:0]       r_tx;
    logic [7:0]       n_tx;
    logic [PIX_W-1:0] r_pidx;
    logic [PIX_W-1:0] n_pidx;
    logic [7:0]       r_red;
    logic [7:0]       n_red;
    logic [7:0]       r_green;
    logic [7:0]       n_green;
    logic [7:0]       r_blue;
    logic [7:0]       n_blue;
    logic             r_last;
    logic             n_last;

    logic             out_free;
    logic             last_pix;
    logic             rd_en;

    assign out_free = !r_out_valid || i_out_ready;
    assign last_pix = (r_idx == r_leds - 6'd1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && out_free && i_cmd.is_frame) begin
                    n_state = B_READ;
                end
            end
            B_READ: n_state = B_SHOW;
            B_SHOW: begin
                if (out_free) begin
                    n_state = last_pix ? B_ACK : B_READ;
                end
            end
            B_ACK: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        o_frame_done = 1'b0;
        rd_en        = 1'b0;
        n_idx        = r_idx;
        n_leds       = r_leds;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_kind       = r_kind;
        n_tx         = r_tx;
        n_pidx       = r_pidx;
        n_red        = r_red;
        n_green      = r_green;
        n_blue       = r_blue;
        n_last       = r_last;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_frame) begin
                        n_idx  = '0;
                        n_leds = i_cmd.leds;
                    end else begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_TX;
                        n_tx        = i_cmd.tx_byte;
                        n_pidx      = '0;
                        n_red       = 8'd0;
                        n_green     = 8'd0;
                        n_blue      = 8'd0;
                        n_last      = 1'b1;
                    end
                end
            end
            B_READ: rd_en = 1'b1;
            B_SHOW: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_PIX;
                    n_tx        = 8'd0;
                    n_pidx      = r_idx;
                    n_red       = r_rd_red;
                    n_green     = r_rd_green;
                    n_blue      = r_rd_blue;
                    n_last      = 1'b0;
                    n_idx       = r_idx + 6'd1;
                end
            end
            B_ACK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_kind       = KIND_TX;
                    n_tx         = ACK_OK;
                    n_pidx       = '0;
                    n_red        = 8'd0;
                    n_green      = 8'd0;
                    n_blue       = 8'd0;
                    n_last       = 1'b1;
                    o_frame_done = 1'b1;
                end
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            unique case (i_wr.lane)
                LANE_RED:   r_mem_red[i_wr.addr]   <= i_wr.data;
                LANE_GREEN: r_mem_green[i_wr.addr] <= i_wr.data;
                LANE_BLUE:  r_mem_blue[i_wr.addr]  <= i_wr.data;
                default:    r_mem_blue[i_wr.addr]  <= i_wr.data;
            endcase
        end
        if (rd_en) begin
            r_rd_red   <= r_mem_red[r_idx];
            r_rd_green <= r_mem_green[r_idx];
            r_rd_blue  <= r_mem_blue[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_leds  <= n_leds;
        r_kind  <= n_kind;
        r_tx    <= n_tx;
        r_pidx  <= n_pidx;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_last  <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx;
    assign o_pixel_index = r_pidx;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_last        = r_last;

    `LFRX_ASSERT(a_pop_frame_count, i_clk, i_rst_n,
        (o_pop && i_cmd.is_frame) |-> (i_cmd.leds != '0 && i_cmd.leds <= 6'(LED_COUNT)))
    `LFRX_ASSERT(a_show_in_range, i_clk, i_rst_n,
        (r_state == B_SHOW) |-> (r_idx < r_leds))
    `LFRX_ASSERT(a_done_ends_frame, i_clk, i_rst_n,
        o_frame_done |=> (r_out_valid && r_last && r_tx == ACK_OK && r_state == B_IDLE))

endmodule

[rtl/led_frame_serial_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame serial receiver
// Decodes a serial LED frame protocol into pixel writes, acknowledges and
// status replies, with an APB-style port for the timing registers.
// ----------------------------------------------------------------------------
// Input beats carry either a received byte or a millisecond tick; output beats
// carry a transmit byte or a pixel write, with o_last on the final beat that
// one input beat causes. Both channels use valid/ready.
// An input beat is taken whenever the two-entry command queue has room and no
// burst holds it off; a reply goes through the queue into the output register.
// The final colour byte of a frame starts a burst of pixel beats, each pixel
// read from the frame store (B_READ) and then shown (B_SHOW), followed by one
// acknowledge beat (B_ACK).
// While that burst runs, colour bytes and ticks of the next frame are held
// off; header, count and status beats are still taken while the queue has room.
// When the output is stalled the output register holds its beat, the queue
// fills and o_in_ready falls after two further commands.
// Reset clears the framing state, the millisecond counters and the queue, and
// loads the registers with a 33 ms frame interval and a 1000 ms timeout.
// Registers: min_interval_ms at address 0, timeout_ms at address 4.
// ----------------------------------------------------------------------------
module led_frame_serial_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [7:0]                 i_rx_byte,
    input  logic [7:0]                 i_fifo_level,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [7:0]                 o_tx_byte,
    output logic [lfrx_pkg::PIX_W-1:0] o_pixel_index,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic                       o_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lfrx_pkg::*;

    logic [7:0]  r_min_interval;
    logic [15:0] r_timeout;
    logic        cfg_wr;

    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    t_cmd        push_cmd;
    t_cmd        head_cmd;
    t_wr         store_wr;
    logic        frame_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INTERVAL_RST;
            r_timeout      <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MIN_INTERVAL) begin
                r_min_interval <= pwdata[7:0];
            end else begin
                r_timeout <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_INTERVAL: prdata = {24'd0, r_min_interval};
            REG_TIMEOUT:      prdata = {16'd0, r_timeout};
            default:          prdata = 32'd0;
        endcase
    end

    lfrx_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_mode         (i_mode),
        .i_rx_byte      (i_rx_byte),
        .i_fifo_level   (i_fifo_level),
        .i_min_interval (r_min_interval),
        .i_timeout      (r_timeout),
        .i_q_full       (q_full),
        .i_frame_done   (frame_done),
        .o_push         (q_push),
        .o_cmd          (push_cmd),
        .o_wr           (store_wr)
    );

    lfrx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    lfrx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .o_frame_done  (frame_done),
        .i_wr          (store_wr),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last        (o_last)
    );

endmodule
